[design/assert_macros.svh]
// Concurrent assertion helpers. Define NO_ASSERTIONS to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

[design/rc4v_pkg.sv]
package rc4v_pkg;

	localparam int unsigned BYTE_W             = 8;
	localparam int unsigned CNT_W              = 9;
	localparam int unsigned PERM_DEPTH         = 256;
	localparam int unsigned KEY_STORE_DEPTH_DEF = 256;
	localparam logic [BYTE_W-1:0] KEY_OFFSET   = 8'd128;
	localparam logic [BYTE_W-1:0] LAST_STEP    = 8'hFF;

	typedef enum logic {
		ITEM_KEY  = 1'b0,
		ITEM_DATA = 1'b1
	} item_op_t;

	typedef struct packed {
		logic              operation;
		logic [BYTE_W-1:0] value;
		logic              key_last;
	} in_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data_out;
		logic              not_keyed;
	} out_item_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_KEY_WR,
		OP_INIT,
		OP_K_RDS,
		OP_K_RDJ,
		OP_K_WRS,
		OP_K_WRJ,
		OP_D_RDI,
		OP_D_RDJ,
		OP_D_WRI,
		OP_D_WRJ,
		OP_NK
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic keyed;
		logic s_last;
		logic out_free;
	} dp_status_t;

endpackage

[design/rc4v_ctrl.sv]
`include "assert_macros.svh"

module rc4v_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rc4v_pkg::in_item_t  in_item,
	input  rc4v_pkg::dp_status_t status,
	output rc4v_pkg::dp_cmd_t   cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_K_RDS,
		ST_K_RDJ,
		ST_K_WRS,
		ST_K_WRJ,
		ST_D_RDJ,
		ST_D_WRI,
		ST_D_WRJ,
		ST_NK
	} state_t;

	state_t state_q;
	state_t state_nxt;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_nxt    = state_q;
		cmd.op       = rc4v_pkg::OP_NONE;
		cmd.out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_item.operation == rc4v_pkg::ITEM_KEY) begin
						cmd.op = rc4v_pkg::OP_KEY_WR;
						if (in_item.key_last) begin
							state_nxt = ST_INIT;
						end
					end else if (status.keyed) begin
						cmd.op    = rc4v_pkg::OP_D_RDI;
						state_nxt = ST_D_RDJ;
					end else begin
						state_nxt = ST_NK;
					end
				end
			end
			ST_INIT: begin
				cmd.op = rc4v_pkg::OP_INIT;
				if (status.s_last) begin
					state_nxt = ST_K_RDS;
				end
			end
			ST_K_RDS: begin
				cmd.op    = rc4v_pkg::OP_K_RDS;
				state_nxt = ST_K_RDJ;
			end
			ST_K_RDJ: begin
				cmd.op    = rc4v_pkg::OP_K_RDJ;
				state_nxt = ST_K_WRS;
			end
			ST_K_WRS: begin
				cmd.op    = rc4v_pkg::OP_K_WRS;
				state_nxt = ST_K_WRJ;
			end
			ST_K_WRJ: begin
				cmd.op    = rc4v_pkg::OP_K_WRJ;
				state_nxt = status.s_last ? ST_IDLE : ST_K_RDS;
			end
			ST_D_RDJ: begin
				cmd.op    = rc4v_pkg::OP_D_RDJ;
				state_nxt = ST_D_WRI;
			end
			ST_D_WRI: begin
				cmd.op    = rc4v_pkg::OP_D_WRI;
				state_nxt = ST_D_WRJ;
			end
			ST_D_WRJ: begin
				// repeat the final swap write while the output slot is full
				cmd.op = rc4v_pkg::OP_D_WRJ;
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			ST_NK: begin
				cmd.op = rc4v_pkg::OP_NK;
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	`ASSERT_PROP(a_nk_unkeyed, clk, arst_n, (state_q == ST_NK) |-> !status.keyed, "unkeyed path taken while keyed")
	`ASSERT_PROP(a_sched_after_init, clk, arst_n, (state_q == ST_INIT && status.s_last) |=> (state_q == ST_K_RDS), "schedule did not follow table init")
	`ASSERT_NEVER(a_load_when_full, clk, arst_n, cmd.out_load && !status.out_free, "result loaded into a full output slot")

endmodule

[design/rc4v_dp.sv]
`include "assert_macros.svh"

module rc4v_dp #(
	parameter int unsigned KEY_STORE_DEPTH = rc4v_pkg::KEY_STORE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rc4v_pkg::in_item_t   in_item,
	input  rc4v_pkg::dp_cmd_t    cmd,
	output rc4v_pkg::dp_status_t status,
	output logic                 out_valid,
	input  logic                 out_ready,
	output rc4v_pkg::out_item_t  out_item
);

	localparam int unsigned KW = (KEY_STORE_DEPTH > 1) ? $clog2(KEY_STORE_DEPTH) : 1;
	localparam logic [rc4v_pkg::CNT_W-1:0] CNT_LIMIT = rc4v_pkg::CNT_W'(KEY_STORE_DEPTH);
	localparam logic [rc4v_pkg::CNT_W-1:0] CNT_ONE   = rc4v_pkg::CNT_W'(1);

	logic [rc4v_pkg::BYTE_W-1:0] perm_mem [rc4v_pkg::PERM_DEPTH];
	logic [rc4v_pkg::BYTE_W-1:0] key_mem  [KEY_STORE_DEPTH];

	logic [rc4v_pkg::BYTE_W-1:0] perm_rd_q;
	logic [rc4v_pkg::BYTE_W-1:0] key_rd_q;
	logic [rc4v_pkg::BYTE_W-1:0] si_q;
	logic [rc4v_pkg::BYTE_W-1:0] sj_q;
	logic [rc4v_pkg::BYTE_W-1:0] data_q;
	logic                        keqi_q;
	logic                        keqj_q;

	logic [rc4v_pkg::CNT_W-1:0]  key_count_q;
	logic [rc4v_pkg::CNT_W-1:0]  kidx_q;
	logic [rc4v_pkg::BYTE_W-1:0] s_q;
	logic [rc4v_pkg::BYTE_W-1:0] i_q;
	logic [rc4v_pkg::BYTE_W-1:0] j_q;
	logic                        keyed_q;
	logic                        out_valid_q;
	rc4v_pkg::out_item_t         out_item_q;

	logic                        perm_we;
	logic                        perm_re;
	logic [rc4v_pkg::BYTE_W-1:0] perm_waddr;
	logic [rc4v_pkg::BYTE_W-1:0] perm_wdata;
	logic [rc4v_pkg::BYTE_W-1:0] perm_raddr;
	logic [rc4v_pkg::BYTE_W-1:0] j_sched;
	logic [rc4v_pkg::BYTE_W-1:0] i_inc;
	logic [rc4v_pkg::BYTE_W-1:0] j_data;
	logic [rc4v_pkg::BYTE_W-1:0] k_addr;
	logic [rc4v_pkg::BYTE_W-1:0] ks_byte;
	logic [rc4v_pkg::CNT_W-1:0]  kidx_inc;
	logic                        key_we;

	assign j_sched  = j_q + perm_rd_q + key_rd_q + rc4v_pkg::KEY_OFFSET;
	assign i_inc    = i_q + 8'd1;
	assign j_data   = j_q + perm_rd_q;
	assign k_addr   = si_q + perm_rd_q;
	assign kidx_inc = kidx_q + CNT_ONE;
	assign key_we   = (cmd.op == rc4v_pkg::OP_KEY_WR) && (key_count_q < CNT_LIMIT);

	// swapped entries are not yet all in memory when the keystream byte is read
	assign ks_byte = keqi_q ? sj_q : (keqj_q ? si_q : perm_rd_q);

	always_comb begin
		perm_we    = 1'b0;
		perm_re    = 1'b0;
		perm_waddr = s_q;
		perm_wdata = perm_rd_q;
		perm_raddr = s_q;
		case (cmd.op)
			rc4v_pkg::OP_INIT: begin
				perm_we    = 1'b1;
				perm_wdata = s_q;
			end
			rc4v_pkg::OP_K_RDS: begin
				perm_re = 1'b1;
			end
			rc4v_pkg::OP_K_RDJ: begin
				perm_re    = 1'b1;
				perm_raddr = j_sched;
			end
			rc4v_pkg::OP_K_WRS: begin
				perm_we = 1'b1;
			end
			rc4v_pkg::OP_K_WRJ, rc4v_pkg::OP_D_WRJ: begin
				perm_we    = 1'b1;
				perm_waddr = j_q;
				perm_wdata = si_q;
			end
			rc4v_pkg::OP_D_RDI: begin
				perm_re    = 1'b1;
				perm_raddr = i_inc;
			end
			rc4v_pkg::OP_D_RDJ: begin
				perm_re    = 1'b1;
				perm_raddr = j_data;
			end
			rc4v_pkg::OP_D_WRI: begin
				perm_we    = 1'b1;
				perm_waddr = i_q;
				perm_re    = 1'b1;
				perm_raddr = k_addr;
			end
			default: begin
				perm_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (perm_we) begin
			perm_mem[perm_waddr] <= perm_wdata;
		end
		if (perm_re) begin
			perm_rd_q <= perm_mem[perm_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[key_count_q[KW-1:0]] <= in_item.value;
		end
		if (cmd.op == rc4v_pkg::OP_K_RDS) begin
			key_rd_q <= key_mem[kidx_q[KW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			rc4v_pkg::OP_K_RDJ, rc4v_pkg::OP_D_RDJ: begin
				si_q <= perm_rd_q;
			end
			rc4v_pkg::OP_D_RDI: begin
				data_q <= in_item.value;
			end
			rc4v_pkg::OP_D_WRI: begin
				sj_q   <= perm_rd_q;
				keqi_q <= (k_addr == i_q);
				keqj_q <= (k_addr == j_q);
			end
			default: begin
				si_q <= si_q;
			end
		endcase
		if (cmd.out_load) begin
			if (cmd.op == rc4v_pkg::OP_NK) begin
				out_item_q.data_out  <= '0;
				out_item_q.not_keyed <= 1'b1;
			end else begin
				out_item_q.data_out  <= ks_byte ^ data_q;
				out_item_q.not_keyed <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= '0;
			kidx_q      <= '0;
			s_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			keyed_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (cmd.op)
				rc4v_pkg::OP_KEY_WR: begin
					if (key_we) begin
						key_count_q <= key_count_q + CNT_ONE;
					end
				end
				rc4v_pkg::OP_INIT: begin
					s_q    <= s_q + 8'd1;
					j_q    <= '0;
					kidx_q <= '0;
				end
				rc4v_pkg::OP_K_RDJ: begin
					j_q <= j_sched;
				end
				rc4v_pkg::OP_K_WRJ: begin
					s_q <= s_q + 8'd1;
					if (s_q == rc4v_pkg::LAST_STEP) begin
						i_q         <= '0;
						j_q         <= '0;
						kidx_q      <= '0;
						key_count_q <= '0;
						keyed_q     <= 1'b1;
					end else if (kidx_inc == key_count_q) begin
						kidx_q <= '0;
					end else begin
						kidx_q <= kidx_inc;
					end
				end
				rc4v_pkg::OP_D_RDI: begin
					i_q <= i_inc;
				end
				rc4v_pkg::OP_D_RDJ: begin
					j_q <= j_data;
				end
				default: begin
					s_q <= s_q;
				end
			endcase
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.keyed    = keyed_q;
	assign status.s_last   = (s_q == rc4v_pkg::LAST_STEP);
	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign out_item        = out_item_q;

	`ASSERT_PROP(a_count_bound, clk, arst_n, key_count_q <= CNT_LIMIT, "key count past store depth")
	`ASSERT_PROP(a_kidx_in_key, clk, arst_n, (cmd.op == rc4v_pkg::OP_K_RDS) |-> (kidx_q < key_count_q), "key index outside stored key")
	`ASSERT_PROP(a_keyed_rise, clk, arst_n, $rose(keyed_q) |-> $past(cmd.op == rc4v_pkg::OP_K_WRJ), "keyed set outside schedule end")

endmodule

[design/rc4_variant_stream_cipher.sv]
// RC4-style byte stream cipher with a modified key schedule (key byte + 128).
// Input channel (in_valid/in_ready/in_item): operation selects key byte or
// data byte. Key bytes fill the key store one per transfer; bytes beyond
// KEY_STORE_DEPTH are dropped. A key byte with key_last set starts the key
// schedule: table init writes every entry, then each swap step reads S[s],
// reads S[j], writes S[s] and writes S[j]; the block takes no input until
// the schedule ends. A plain key byte leaves the block ready for input.
// Data bytes: output = data XOR keystream; the same call decrypts. A keyed
// data byte steps through D_RDJ, D_WRI and D_WRJ, loading its result in
// D_WRJ once the output slot is free; these steps are set by the single
// read and single write port of the permutation memory (two reads, two swap
// writes and the keystream read). Data sent before any key schedule returns
// zero with not_keyed set, loaded in state NK once the output slot is free.
// Output channel (out_valid/out_ready/out_item) is one register: a new item
// may be taken while a result waits; if out_ready stays low the block holds
// the next result in its last step and takes no further input.
// Reset clears indices, key count and the keyed flag; the permutation is
// rebuilt by every key schedule, so no memory clearing pass is needed.
module rc4_variant_stream_cipher #(
	parameter int unsigned KEY_STORE_DEPTH = rc4v_pkg::KEY_STORE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rc4v_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output rc4v_pkg::out_item_t out_item
);

	rc4v_pkg::dp_cmd_t    cmd;
	rc4v_pkg::dp_status_t status;

	rc4v_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.status   (status),
		.cmd      (cmd)
	);

	rc4v_dp #(
		.KEY_STORE_DEPTH (KEY_STORE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule
